>>> rtl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

	// Binary input width and packed BCD width (ten digits of four bits)
	localparam int BIN_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;

	// Character codes
	localparam logic [6:0] ASCII_ZERO  = 7'd48;
	localparam logic [6:0] ASCII_MINUS = 7'd45;

	// Step counter: conversion runs one step per input bit, output one step per digit
	localparam logic [4:0] CONV_LAST = 5'(BIN_W - 1);
	localparam logic [4:0] EMIT_LAST = 5'(NUM_DIGITS - 1);

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} sitda_state_t;

endpackage

>>> rtl/sitda_dabble_step.sv
// One shift-and-add-3 step of the binary to BCD converter, shared across all input bits.
`timescale 1ns / 1ps

module sitda_dabble_step import sitda_pkg::*; (
	input  logic [BCD_W-1:0] bcd,
	input  logic             bit_in,
	output logic [BCD_W-1:0] bcd_next
);

	logic [BCD_W-1:0] adj;

	// Correct every digit of five or more, then shift in the next binary bit
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd[4*i +: 4];
			end
		end
		bcd_next = {adj[BCD_W-2:0], bit_in};
	end

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per strobe.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low. The magnitude is turned
// into ten BCD digits by a single shift-and-add-3 unit, one input bit per cycle;
// for a negative value a leading '-' is strobed out in the cycle right after the
// conversion. The digits are then walked from the most significant, choosing one
// character per cycle once the first non-zero digit (or the units digit) is
// reached, with last high on the units digit; each chosen character reaches the
// ports in the next cycle, so the final one is out while busy is already low.
// A new word can be taken only once the conversion loop and the digit walk are
// done and busy is low again. Each character is on char_code and last for
// exactly one cycle, marked by strobe; the receiver cannot stall it.
module signed_int_to_decimal_ascii import sitda_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [31:0] value,
	output logic              strobe,
	output logic [6:0]        char_code,
	output logic              last
);

	sitda_state_t     state_q, state_d;
	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] bcd_step;
	logic [4:0]       cnt_q;
	logic             neg_q;
	logic             started_q;

	logic             accept;
	logic [BIN_W-1:0] mag;
	logic [3:0]       top_digit;
	logic             emit_last;
	logic             emit_now;
	logic             out_stb_d;
	logic [6:0]       out_char_d;
	logic             out_last_d;

	logic             strobe_q;
	logic [6:0]       char_q;
	logic             last_q;

	sitda_dabble_step u_step (
		.bcd      (bcd_q),
		.bit_in   (bin_q[BIN_W-1]),
		.bcd_next (bcd_step)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign mag       = value[BIN_W-1] ? (~value + 32'd1) : value;
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign emit_last = (cnt_q == EMIT_LAST);
	assign emit_now  = started_q || (top_digit != 4'd0) || emit_last;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the sequencer and decide what to strobe out
	always_comb begin
		state_d    = state_q;
		out_stb_d  = 1'b0;
		out_char_d = ASCII_ZERO;
		out_last_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				if (cnt_q == CONV_LAST) begin
					state_d    = ST_EMIT;
					out_stb_d  = neg_q;
					out_char_d = ASCII_MINUS;
				end
			end
			ST_EMIT: begin
				out_stb_d  = emit_now;
				out_char_d = ASCII_ZERO + {3'd0, top_digit};
				out_last_d = emit_last;
				if (emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Step counter and leading-zero flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 5'd0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q     <= 5'd0;
					started_q <= 1'b0;
				end
				ST_CONVERT: begin
					cnt_q <= (cnt_q == CONV_LAST) ? 5'd0 : cnt_q + 5'd1;
				end
				ST_EMIT: begin
					cnt_q <= cnt_q + 5'd1;
					if (emit_now) begin
						started_q <= 1'b1;
					end
				end
				default: begin
					cnt_q <= 5'd0;
				end
			endcase
		end
	end

	// Load the magnitude, run the shared BCD step, then drop one digit per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					bin_q <= mag;
					bcd_q <= '0;
					neg_q <= value[BIN_W-1];
				end
			end
			ST_CONVERT: begin
				bin_q <= {bin_q[BIN_W-2:0], 1'b0};
				bcd_q <= bcd_step;
			end
			ST_EMIT: begin
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	// Register the outgoing word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= out_stb_d;
		end
	end

	always_ff @(posedge clk) begin
		char_q <= out_char_d;
		last_q <= out_last_d;
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

	// A character only follows a cycle of work
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("character strobed without a word in progress");

	// The final character frees the block for the next word
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final character while still busy");

	// Only the minus sign or a digit leaves the block
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (char_code == ASCII_MINUS) ||
			((char_code >= ASCII_ZERO) && (char_code <= ASCII_ZERO + 7'd9)))
		else $error("illegal character code");

	// The sign never ends a word
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (char_code == ASCII_MINUS) |-> !last)
		else $error("minus sign marked as final character");

	// An accepted word starts the conversion
	a_accept_converts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_CONVERT)
		else $error("accepted word did not start conversion");

endmodule
